// ----- sv/valve_actuator_controller_unit_assert.svh -----
// Assertion macros shared by the valve actuator controller.
`ifndef VALVE_ACTUATOR_CONTROLLER_UNIT_ASSERT_SVH
`define VALVE_ACTUATOR_CONTROLLER_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define VAC_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("valve controller check failed");

// Consequent must hold in the cycle after the antecedent.
`define VAC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("valve controller check failed");

`endif

// ----- sv/vac_pkg.sv -----
package vac_pkg;

  // Valve state codes.
  localparam logic [2:0] ST_CLOSED  = 3'd0;
  localparam logic [2:0] ST_OPENING = 3'd1;
  localparam logic [2:0] ST_OPENED  = 3'd2;
  localparam logic [2:0] ST_CLOSING = 3'd3;
  localparam logic [2:0] ST_STOPF   = 3'd4;
  localparam logic [2:0] ST_FAILURE = 3'd5;

  // Switch readings.
  localparam logic [1:0] SW_LOCAL = 2'd0;
  localparam logic [1:0] SW_FAULT = 2'd1;
  localparam logic [1:0] SW_AUTO  = 2'd2;

  // LED colors.
  localparam logic [1:0] LED_DARK  = 2'd0;
  localparam logic [1:0] LED_RED   = 2'd1;
  localparam logic [1:0] LED_GREEN = 2'd2;

  localparam logic [11:0] DUTY_FULL = 12'd4095;

  // Configuration register indexes and reset values.
  localparam logic [1:0] CFG_TRAVEL_TIME = 2'd0;
  localparam logic [1:0] CFG_BLINK_ON    = 2'd1;
  localparam logic [1:0] CFG_BLINK_OFF   = 2'd2;

  localparam logic [15:0] TRAVEL_TIME_RST = 16'd2000;
  localparam logic [15:0] BLINK_ON_RST    = 16'd500;
  localparam logic [15:0] BLINK_OFF_RST   = 16'd250;

  typedef struct packed {
    logic [1:0]  switch_position;
    logic        open_command;
    logic [15:0] elapsed_ms;
  } vac_in_t;

  typedef struct packed {
    logic [2:0]  valve_state;
    logic        auto_mode;
    logic [11:0] led_red;
    logic [11:0] led_green;
    logic        alarm_raised;
    logic        alarm_cleared;
  } vac_out_t;

  // Control state carried between passes.
  typedef struct packed {
    logic [2:0] state;
    logic       mode_auto;
    logic [1:0] led;
  } vac_ctrl_t;

endpackage

// ----- sv/valve_actuator_controller_unit.sv -----
// Channel   Direction  Handshake              Payload
// in_       input      in_valid / in_ready    vac_in_t  (switch, command, elapsed ms)
// out_      output     out_valid / out_ready  vac_out_t (state, mode, LEDs, alarm pulses)
// cfg_      input      cfg_we                 cfg_index, cfg_wdata (16 bit)
//
// Each item is one control-loop pass, computed combinationally; an item may be accepted
// every cycle. Its result appears in the output register on the following cycle.
// in_ready is high when the output register is empty or being taken, so a stall
// on out_ready holds off the input only while a result is waiting.
// Synchronous active-low reset clears the valve state and timers and loads the
// register defaults (travel 2000 ms, blink on 500 ms, blink off 250 ms).
module valve_actuator_controller_unit #(
  parameter int TIMER_WIDTH = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  vac_pkg::vac_in_t in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output vac_pkg::vac_out_t out_data,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [15:0]      cfg_wdata
);
  import vac_pkg::*;

  logic [15:0]            travel_time_r;
  logic [15:0]            blink_on_r;
  logic [15:0]            blink_off_r;
  vac_ctrl_t              ctrl_r;
  vac_ctrl_t              ctrl_nxt;
  logic [TIMER_WIDTH-1:0] travel_r;
  logic [TIMER_WIDTH-1:0] travel_nxt;
  logic [TIMER_WIDTH:0]   blink_r;
  logic [TIMER_WIDTH:0]   blink_nxt;
  logic                   out_valid_r;
  vac_out_t               out_data_r;
  vac_out_t               result;
  logic                   in_accept;

  assign in_ready  = !out_valid_r || out_ready;
  assign in_accept = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  vac_step #(
    .TIMER_WIDTH(TIMER_WIDTH)
  ) u_step (
    .ctrl_q         (ctrl_r),
    .travel_q       (travel_r),
    .blink_q        (blink_r),
    .item           (in_data),
    .travel_time_ms (travel_time_r),
    .blink_on_ms    (blink_on_r),
    .blink_off_ms   (blink_off_r),
    .ctrl_nxt       (ctrl_nxt),
    .travel_nxt     (travel_nxt),
    .blink_nxt      (blink_nxt),
    .result         (result)
  );

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      travel_time_r <= TRAVEL_TIME_RST;
      blink_on_r    <= BLINK_ON_RST;
      blink_off_r   <= BLINK_OFF_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_TRAVEL_TIME: travel_time_r <= cfg_wdata;
        CFG_BLINK_ON:    blink_on_r    <= cfg_wdata;
        CFG_BLINK_OFF:   blink_off_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Valve state and timers advance on each accepted item.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_r.state     <= ST_CLOSED;
      ctrl_r.mode_auto <= 1'b0;
      ctrl_r.led       <= LED_DARK;
      travel_r         <= '0;
      blink_r          <= '0;
    end else if (in_accept) begin
      ctrl_r   <= ctrl_nxt;
      travel_r <= travel_nxt;
      blink_r  <= blink_nxt;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      out_data_r <= result;
    end
  end

`include "valve_actuator_controller_unit_assert.svh"

  `VAC_ASSERT_NEXT(a_accept_gives_result, in_accept, out_valid_r)
  `VAC_ASSERT_SAME(a_raise_in_failure, out_valid_r && out_data_r.alarm_raised, out_data_r.valve_state == ST_FAILURE)
  `VAC_ASSERT_SAME(a_clear_to_closed, out_valid_r && out_data_r.alarm_cleared, out_data_r.valve_state == ST_CLOSED)
  `VAC_ASSERT_SAME(a_state_code_range, 1'b1, ctrl_r.state <= ST_FAILURE)

endmodule

// ----- sv/vac_step.sv -----
module vac_step #(
  parameter int TIMER_WIDTH = 16
) (
  input  vac_pkg::vac_ctrl_t    ctrl_q,
  input  logic [TIMER_WIDTH-1:0] travel_q,
  input  logic [TIMER_WIDTH:0]   blink_q,
  input  vac_pkg::vac_in_t      item,
  input  logic [15:0]           travel_time_ms,
  input  logic [15:0]           blink_on_ms,
  input  logic [15:0]           blink_off_ms,
  output vac_pkg::vac_ctrl_t    ctrl_nxt,
  output logic [TIMER_WIDTH-1:0] travel_nxt,
  output logic [TIMER_WIDTH:0]   blink_nxt,
  output vac_pkg::vac_out_t     result
);
  import vac_pkg::*;

  localparam int TW  = TIMER_WIDTH;
  localparam int BW  = TIMER_WIDTH + 1;
  localparam int TCW = (TW > 16) ? TW : 16;
  localparam int BCW = (BW > 17) ? BW : 17;
  localparam int TAW = TCW + 1;
  localparam int BAW = BCW + 1;

  logic [TAW-1:0] travel_sum;
  logic [BAW-1:0] blink_sum;
  logic [TW-1:0]  travel_adv;
  logic [BW-1:0]  blink_adv;
  logic [16:0]    blink_period;

  // Saturating advance of both timers.
  assign travel_sum   = TAW'(travel_q) + TAW'(item.elapsed_ms);
  assign blink_sum    = BAW'(blink_q) + BAW'(item.elapsed_ms);
  assign travel_adv   = (travel_sum > TAW'({TW{1'b1}})) ? {TW{1'b1}} : travel_sum[TW-1:0];
  assign blink_adv    = (blink_sum > BAW'({BW{1'b1}})) ? {BW{1'b1}} : blink_sum[BW-1:0];
  assign blink_period = 17'(blink_on_ms) + 17'(blink_off_ms);

  logic [TW-1:0] tr;
  logic [BW-1:0] bl;
  logic [2:0]    st_cmd;
  logic [2:0]    st_new;
  logic [1:0]    led;
  logic [1:0]    blink_col;
  logic          mode;
  logic          moving;
  logic          done;
  logic          raised;
  logic          cleared;

  // Mode, switch and command evaluation, then motion and LED update.
  always_comb begin
    tr        = travel_adv;
    bl        = blink_adv;
    mode      = ctrl_q.mode_auto;
    st_cmd    = ctrl_q.state;
    led       = ctrl_q.led;
    raised    = 1'b0;
    cleared   = 1'b0;
    moving    = 1'b0;
    blink_col = LED_GREEN;

    if (item.switch_position == SW_LOCAL) begin
      mode = 1'b0;
    end else if (item.switch_position == SW_AUTO) begin
      mode = 1'b1;
    end

    // The previous state always equals the state at the start of a pass.
    if (item.switch_position == SW_FAULT) begin
      if (ctrl_q.state == ST_OPENED || ctrl_q.state == ST_OPENING) begin
        tr     = '0;
        st_cmd = ST_STOPF;
      end
      if (ctrl_q.state == ST_CLOSED) begin
        st_cmd = ST_FAILURE;
        raised = 1'b1;
      end
    end else if (!mode) begin
      if (item.open_command &&
          (ctrl_q.state == ST_CLOSED || ctrl_q.state == ST_CLOSING)) begin
        tr     = '0;
        st_cmd = ST_OPENING;
      end
      if (!item.open_command &&
          (ctrl_q.state == ST_OPENED || ctrl_q.state == ST_OPENING)) begin
        tr     = '0;
        st_cmd = ST_CLOSING;
      end
      if (!item.open_command && ctrl_q.state == ST_FAILURE) begin
        st_cmd  = ST_CLOSED;
        cleared = 1'b1;
      end
    end

    done   = (TCW'(tr) > TCW'(travel_time_ms));
    st_new = st_cmd;

    unique case (st_cmd)
      ST_FAILURE: led = LED_RED;
      ST_OPENED:  led = LED_GREEN;
      ST_CLOSED:  led = LED_DARK;
      ST_OPENING: begin
        moving = 1'b1;
        if (done) begin
          tr     = '0;
          st_new = ST_OPENED;
        end
      end
      ST_CLOSING: begin
        moving = 1'b1;
        if (done) begin
          tr     = '0;
          st_new = ST_CLOSED;
        end
      end
      ST_STOPF: begin
        moving    = 1'b1;
        blink_col = LED_RED;
        if (done) begin
          tr     = '0;
          st_new = ST_CLOSED;
        end
      end
      default: ;
    endcase

    // Blinking while the valve moves.
    if (moving) begin
      if (BCW'(bl) > BCW'(blink_on_ms)) begin
        led = LED_DARK;
      end
      if (BCW'(bl) > BCW'(blink_period)) begin
        led = blink_col;
        bl  = '0;
      end
    end
  end

  assign ctrl_nxt.state     = st_new;
  assign ctrl_nxt.mode_auto = mode;
  assign ctrl_nxt.led       = led;
  assign travel_nxt         = tr;
  assign blink_nxt          = bl;

  assign result.valve_state   = st_new;
  assign result.auto_mode     = mode;
  assign result.led_red       = (led == LED_RED) ? DUTY_FULL : 12'd0;
  assign result.led_green     = (led == LED_GREEN) ? DUTY_FULL : 12'd0;
  assign result.alarm_raised  = raised;
  assign result.alarm_cleared = cleared;

endmodule

// ----- bench/tb_valve_actuator_controller_unit.sv -----
`timescale 1ns / 100ps

module tb_valve_actuator_controller_unit;
  import vac_pkg::*;

  // Switch code 3 keeps the present mode and is not a fault.
  localparam logic [1:0] SW_HOLD = 2'd3;
  localparam int CYCLE_LIMIT = 400000;

  logic clk;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  vac_in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  vac_out_t out_data;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = CFG_TRAVEL_TIME;
  logic [15:0] cfg_wdata = '0;

  valve_actuator_controller_unit #(
    .TIMER_WIDTH(16)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  // Control-loop passes still to be offered and valve status still to arrive.
  vac_in_t loop_passes[$];
  vac_out_t status_q[$];

  int send_idle_pct = 27;
  int recv_idle_pct = 69;
  int bad_count = 0;
  int cycle_count = 0;
  logic cmd_bias = 1'b0;

  // Our own copy of the registers and the valve state.
  logic [15:0] travel_ms = TRAVEL_TIME_RST;
  logic [15:0] blink_on = BLINK_ON_RST;
  logic [15:0] blink_off = BLINK_OFF_RST;
  logic mode_auto = 1'b0;
  logic [2:0] cur_st = ST_CLOSED;
  logic [2:0] prev_st = ST_CLOSED;
  logic [15:0] travel_tmr = '0;
  logic [16:0] blink_tmr = '0;
  logic [1:0] led_col = LED_DARK;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Advance the valve by one control-loop pass and return its status.
  function automatic vac_out_t run_control_pass(vac_in_t it);
    vac_out_t r;
    logic [16:0] tsum;
    logic [17:0] bsum;
    logic [16:0] period;
    logic [2:0] moving;
    logic raised;
    logic cleared;
    raised = 1'b0;
    cleared = 1'b0;
    tsum = {1'b0, travel_tmr} + {1'b0, it.elapsed_ms};
    travel_tmr = tsum[16] ? 16'hFFFF : tsum[15:0];
    bsum = {1'b0, blink_tmr} + {2'b00, it.elapsed_ms};
    blink_tmr = bsum[17] ? 17'h1FFFF : bsum[16:0];

    if (it.switch_position == SW_LOCAL) mode_auto = 1'b0;
    else if (it.switch_position == SW_AUTO) mode_auto = 1'b1;

    if (it.switch_position == SW_FAULT) begin
      if (prev_st == ST_OPENED || cur_st == ST_OPENING) begin
        travel_tmr = '0;
        cur_st = ST_STOPF;
      end
      if (prev_st == ST_CLOSED) begin
        cur_st = ST_FAILURE;
        raised = 1'b1;
      end
    end else if (!mode_auto) begin
      if (it.open_command && (cur_st == ST_CLOSED || cur_st == ST_CLOSING)) begin
        travel_tmr = '0;
        cur_st = ST_OPENING;
      end
      if (!it.open_command && (prev_st == ST_OPENED || cur_st == ST_OPENING)) begin
        travel_tmr = '0;
        cur_st = ST_CLOSING;
      end
      if (!it.open_command && prev_st == ST_FAILURE) begin
        cur_st = ST_CLOSED;
        cleared = 1'b1;
      end
    end

    // Steady colors at rest, motion end and blinking while moving.
    moving = cur_st;
    case (cur_st)
      ST_FAILURE: led_col = LED_RED;
      ST_OPENED: led_col = LED_GREEN;
      ST_CLOSED: led_col = LED_DARK;
      ST_OPENING, ST_CLOSING, ST_STOPF: begin
        if (travel_tmr > travel_ms) begin
          travel_tmr = '0;
          cur_st = (moving == ST_OPENING) ? ST_OPENED : ST_CLOSED;
        end
        period = {1'b0, blink_on} + {1'b0, blink_off};
        if (blink_tmr > {1'b0, blink_on}) led_col = LED_DARK;
        if (blink_tmr > period) begin
          led_col = (moving == ST_STOPF) ? LED_RED : LED_GREEN;
          blink_tmr = '0;
        end
      end
      default: ;
    endcase
    prev_st = cur_st;

    r.valve_state = cur_st;
    r.auto_mode = mode_auto;
    r.led_red = (led_col == LED_RED) ? DUTY_FULL : '0;
    r.led_green = (led_col == LED_GREEN) ? DUTY_FULL : '0;
    r.alarm_raised = raised;
    r.alarm_cleared = cleared;
    return r;
  endfunction

  // Driver: predict each accepted item, then offer the next one.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        status_q.push_back(run_control_pass(in_data));
      end
      if (!in_valid || in_ready) begin
        if (loop_passes.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_data <= loop_passes.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each accepted status with the oldest prediction.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (status_q.size() == 0) begin
          bad_count++;
          if (bad_count <= 10) $display("unexpected item at cycle %0d: %p", cycle_count, out_data);
        end else if (out_data.valve_state !== status_q[0].valve_state ||
                     out_data.auto_mode !== status_q[0].auto_mode ||
                     out_data.led_red !== status_q[0].led_red ||
                     out_data.led_green !== status_q[0].led_green ||
                     out_data.alarm_raised !== status_q[0].alarm_raised ||
                     out_data.alarm_cleared !== status_q[0].alarm_cleared) begin
          bad_count++;
          if (bad_count <= 10) begin
            $display("mismatch at cycle %0d: expected %p", cycle_count, status_q[0]);
            $display("                      actual   %p", out_data);
          end
          void'(status_q.pop_front());
        end else begin
          void'(status_q.pop_front());
        end
      end
      out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic void add_pass(logic [1:0] sw, logic cmd, logic [15:0] ms);
    vac_in_t it;
    it.switch_position = sw;
    it.open_command = cmd;
    it.elapsed_ms = ms;
    loop_passes.push_back(it);
  endfunction

  // Mostly local operation with a sticky command, so motions run to completion.
  task automatic queue_random_passes(input int count);
    int k;
    int pick;
    int span;
    logic [1:0] sw;
    logic [15:0] ms;
    span = travel_ms / 3 + 8;
    for (k = 0; k < count; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 62) sw = SW_LOCAL;
      else if (pick < 72) sw = SW_FAULT;
      else if (pick < 88) sw = SW_AUTO;
      else sw = SW_HOLD;
      if ($urandom_range(0, 99) < 25) cmd_bias = ~cmd_bias;
      pick = $urandom_range(0, 99);
      if (pick < 80) ms = 16'($urandom_range(0, span));
      else if (pick < 90) ms = 16'($urandom_range(0, 65535));
      else if (pick < 95) ms = 16'hFFFF;
      else ms = '0;
      add_pass(sw, cmd_bias, ms);
    end
  endtask

  // Wait until every item is taken and every status has arrived.
  task automatic wait_quiet();
    do @(negedge clk);
    while (loop_passes.size() != 0 || in_valid || status_q.size() != 0);
    repeat (4) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic apply_settings(input logic [15:0] t, input logic [15:0] on,
                                input logic [15:0] off);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= CFG_TRAVEL_TIME;
    cfg_wdata <= t;
    @(posedge clk);
    cfg_index <= CFG_BLINK_ON;
    cfg_wdata <= on;
    @(posedge clk);
    cfg_index <= CFG_BLINK_OFF;
    cfg_wdata <= off;
    @(posedge clk);
    cfg_we <= 1'b0;
    travel_ms = t;
    blink_on = on;
    blink_off = off;
    @(negedge clk);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed walk through failure, alarms, modes, motions and fault stops.
    add_pass(SW_LOCAL, 1'b0, 16'd0);
    add_pass(SW_FAULT, 1'b0, 16'd0);
    add_pass(SW_LOCAL, 1'b1, 16'hFFFF);
    add_pass(SW_LOCAL, 1'b0, 16'd0);
    add_pass(SW_LOCAL, 1'b1, 16'd100);
    add_pass(SW_LOCAL, 1'b1, 16'd600);
    add_pass(SW_LOCAL, 1'b1, 16'd200);
    add_pass(SW_FAULT, 1'b1, 16'd50);
    add_pass(SW_LOCAL, 1'b1, 16'd2001);
    add_pass(SW_AUTO, 1'b1, 16'd10);
    add_pass(SW_HOLD, 1'b1, 16'd0);
    add_pass(SW_FAULT, 1'b0, 16'd0);
    add_pass(SW_AUTO, 1'b0, 16'd7);
    add_pass(SW_HOLD, 1'b0, 16'hFFFF);
    add_pass(SW_LOCAL, 1'b0, 16'd0);
    add_pass(SW_HOLD, 1'b1, 16'd1);
    add_pass(SW_LOCAL, 1'b1, 16'd2001);
    add_pass(SW_LOCAL, 1'b1, 16'd5);
    add_pass(SW_FAULT, 1'b1, 16'd5);
    add_pass(SW_LOCAL, 1'b0, 16'd3000);
    add_pass(SW_LOCAL, 1'b1, 16'd0);
    add_pass(SW_LOCAL, 1'b0, 16'd100);
    add_pass(SW_FAULT, 1'b0, 16'd100);
    add_pass(SW_LOCAL, 1'b1, 16'd100);
    queue_random_passes(120);
    wait_quiet();

    // Short timers, with a pause halfway until all status is back.
    apply_settings(16'd300, 16'd40, 16'd60);
    queue_random_passes(60);
    wait_quiet();
    queue_random_passes(60);
    wait_quiet();

    // All registers at zero.
    send_idle_pct <= 69;
    recv_idle_pct <= 27;
    apply_settings(16'd0, 16'd0, 16'd0);
    queue_random_passes(100);
    wait_quiet();

    // All registers at their maximum.
    apply_settings(16'hFFFF, 16'hFFFF, 16'hFFFF);
    queue_random_passes(80);
    wait_quiet();

    // Mixed settings at full rate.
    send_idle_pct <= 0;
    recv_idle_pct <= 0;
    apply_settings(16'd1500, 16'd100, 16'd900);
    queue_random_passes(130);
    wait_quiet();

    if (status_q.size() != 0) bad_count++;
    if (bad_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ----- valve_actuator_controller_unit.f -----
+incdir+sv
sv/vac_pkg.sv
sv/vac_step.sv
sv/valve_actuator_controller_unit.sv
bench/tb_valve_actuator_controller_unit.sv
